FILE: rtl/rtaa_pkg.sv
// ----------------------------------------------------------------------------
// Render target alias allocator package
// Shared types and constants for the slot table, the match unit and the top.
// ----------------------------------------------------------------------------
package rtaa_pkg;

	// Default depth of the slot table.
	localparam int SLOT_COUNT_DEF = 64;

	// Width of slot indices as they appear on the result channel.
	localparam int OUT_IDX_W = 6;

	// Request and result bus widths.
	localparam int REQ_DATA_W = 96;
	localparam int RES_DATA_W = 16;

	// One slot table entry; a request is carried in the same form.
	typedef struct packed {
		logic [7:0]  task_first;
		logic [7:0]  task_last;
		logic [15:0] kind_format;  // kind_flags high byte, pixel_format low byte
		logic [31:0] extent;       // width high half, height low half
		logic [26:0] volume;       // depth, layers, mips packed 11/11/5
		logic        external;
	} slot_entry_t;

	// Outcome of checking one slot against a request.
	typedef struct packed {
		logic        fit;
		slot_entry_t merged;
	} match_t;

	// One result, slot_index in the lowest bits.
	typedef struct packed {
		logic                 swapchain_known;
		logic [OUT_IDX_W-1:0] swapchain_slot;
		logic                 overflow;
		logic                 opened_slot;
		logic [OUT_IDX_W-1:0] slot_index;
	} result_t;

	// Allocator sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/rtaa_slot_match.sv
// ----------------------------------------------------------------------------
// Slot match unit
// Checks one stored slot against a request and forms the widened lifetime.
// ----------------------------------------------------------------------------
module rtaa_slot_match (
	input  rtaa_pkg::slot_entry_t slot,
	input  rtaa_pkg::slot_entry_t req,
	output rtaa_pkg::match_t      result
);

	logic overlap;
	logic same_desc;

	// Lifetimes intersect when each one starts no later than the other ends.
	assign overlap   = (req.task_last >= slot.task_first) && (req.task_first <= slot.task_last);
	assign same_desc = (slot.kind_format == req.kind_format) && (slot.extent == req.extent)
		&& (slot.volume == req.volume);

	// A slot fits when it is free over the request's lifetime, looks identical and neither side is external.
	always_comb begin
		result            = '0;
		result.fit        = !overlap && !slot.external && !req.external && same_desc;
		result.merged     = slot;
		if (req.task_first < slot.task_first) begin
			result.merged.task_first = req.task_first;
		end
		if (req.task_last > slot.task_last) begin
			result.merged.task_last = req.task_last;
		end
	end

endmodule

FILE: rtl/render_target_alias_allocator_top.sv
// ----------------------------------------------------------------------------
// Render target alias allocator
// First-fit aliasing of logical render targets onto physical slots.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_ channel describes one logical render target: its
// inclusive task lifetime and its descriptor. s_tuser[0] set empties the slot
// table and forgets the swapchain slot before the request is handled.
// One result per request leaves on the m_ channel: the assigned slot, whether
// a slot was opened, overflow, and the recorded swapchain slot.
// The slot table sits in one synchronous memory that is scanned one slot per
// cycle from slot 0. A request passes through an accept step, a scan that
// stops at the first fitting slot or at the end of the filled slots, a
// write-back step and the load of the result register.
// A new request is accepted while a finished result waits in the output
// register; when the receiver stalls, the block stops after the write-back of
// its next request until the result register frees up.
// Reset clears the sequencer state, the fill count, the swapchain record and
// the output valid flag; slot contents beyond the fill count are never used, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module render_target_alias_allocator_top #(
	parameter int SLOT_COUNT = rtaa_pkg::SLOT_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request channel.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// first_task[7:0], last_task[15:8], kind_flags[23:16], pixel_format[31:24],
	// image_width[47:32], image_height[63:48], image_depth[74:64],
	// array_layers[85:75], mip_levels[90:86], is_external[91],
	// is_swapchain[92], zero[95:93]
	input  logic [rtaa_pkg::REQ_DATA_W-1:0] s_tdata,
	// clear_table[0]
	input  logic [0:0]                      s_tuser,
	// Result channel.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// slot_index[5:0], opened_slot[6], overflow[7], swapchain_slot[13:8],
	// swapchain_known[14], zero[15]
	output logic [rtaa_pkg::RES_DATA_W-1:0] m_tdata
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int UW = $clog2(SLOT_COUNT + 1);
	localparam int OW = rtaa_pkg::OUT_IDX_W;

	rtaa_pkg::state_t      state_q, state_nx;
	rtaa_pkg::slot_entry_t mem [SLOT_COUNT];
	rtaa_pkg::slot_entry_t rd_data_q;
	rtaa_pkg::slot_entry_t req_q;
	rtaa_pkg::slot_entry_t req_in;
	rtaa_pkg::slot_entry_t merged_q;
	rtaa_pkg::slot_entry_t wr_data;
	rtaa_pkg::match_t      match;
	rtaa_pkg::result_t     res_q, res_nx, out_q;

	logic          req_swap_q;
	logic [UW-1:0] used_q;
	logic [UW-1:0] chk_idx_q;
	logic [UW-1:0] next_idx;
	logic [SW-1:0] found_idx_q;
	logic          found_q;
	logic [OW-1:0] swap_slot_q;
	logic          swap_known_q;
	logic          out_valid_q;
	logic          s_accept;
	logic          out_free;
	logic          scan_end;
	logic          table_full;
	logic          opening;
	logic [SW-1:0] rd_addr;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	logic [SW-1:0] res_idx;
	logic [SW+OW-1:0] res_idx_ext;

	// Unpack the request bus into the slot entry layout.
	always_comb begin
		req_in.task_first  = s_tdata[7:0];
		req_in.task_last   = s_tdata[15:8];
		req_in.kind_format = {s_tdata[23:16], s_tdata[31:24]};
		req_in.extent      = {s_tdata[47:32], s_tdata[63:48]};
		req_in.volume      = {s_tdata[74:64], s_tdata[85:75], s_tdata[90:86]};
		req_in.external    = s_tdata[91];
	end

	assign s_accept   = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign next_idx   = chk_idx_q + UW'(1);
	assign table_full = (used_q == UW'(SLOT_COUNT));
	assign scan_end   = (chk_idx_q >= used_q) || match.fit;
	assign opening    = !found_q && !table_full;

	rtaa_slot_match u_match (
		.slot   (rd_data_q),
		.req    (req_q),
		.result (match)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rtaa_pkg::ST_IDLE: begin
				if (s_accept) begin
					state_nx = rtaa_pkg::ST_SCAN;
				end
			end
			rtaa_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_nx = rtaa_pkg::ST_UPDATE;
				end
			end
			rtaa_pkg::ST_UPDATE: begin
				state_nx = rtaa_pkg::ST_DONE;
			end
			rtaa_pkg::ST_DONE: begin
				if (out_free) begin
					state_nx = rtaa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = rtaa_pkg::ST_IDLE;
			end
		endcase
	end

	// Handshake and memory port controls.
	always_comb begin
		s_tready = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = used_q[SW-1:0];
		wr_data  = req_q;
		case (state_q)
			rtaa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			rtaa_pkg::ST_SCAN: begin
				rd_addr = next_idx[SW-1:0];
			end
			rtaa_pkg::ST_UPDATE: begin
				if (found_q) begin
					wr_en   = 1'b1;
					wr_addr = found_idx_q;
					wr_data = merged_q;
				end else if (!table_full) begin
					wr_en = 1'b1;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Slot table memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Result of the write-back step, swapchain fields after the update.
	always_comb begin
		if (found_q) begin
			res_idx = found_idx_q;
		end else if (table_full) begin
			res_idx = '0;
		end else begin
			res_idx = used_q[SW-1:0];
		end
		res_idx_ext            = {{OW{1'b0}}, res_idx};
		res_nx.slot_index      = res_idx_ext[OW-1:0];
		res_nx.opened_slot     = opening;
		res_nx.overflow        = !found_q && table_full;
		res_nx.swapchain_slot  = swap_slot_q;
		res_nx.swapchain_known = swap_known_q;
		if (opening && req_swap_q) begin
			res_nx.swapchain_slot  = res_idx_ext[OW-1:0];
			res_nx.swapchain_known = 1'b1;
		end
	end

	// Request, scan and result payload registers.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_q      <= req_in;
			req_swap_q <= s_tdata[92];
		end
		if (state_q == rtaa_pkg::ST_SCAN && match.fit) begin
			found_idx_q <= chk_idx_q[SW-1:0];
			merged_q    <= match.merged;
		end
		if (state_q == rtaa_pkg::ST_UPDATE) begin
			res_q <= res_nx;
		end
		if (state_q == rtaa_pkg::ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	// Control state: sequencer, scan position, fill count and swapchain record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rtaa_pkg::ST_IDLE;
			chk_idx_q    <= '0;
			found_q      <= 1'b0;
			used_q       <= '0;
			swap_slot_q  <= '0;
			swap_known_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (s_accept) begin
				chk_idx_q <= '0;
				found_q   <= 1'b0;
				if (s_tuser[0]) begin
					used_q       <= '0;
					swap_slot_q  <= '0;
					swap_known_q <= 1'b0;
				end
			end else if (state_q == rtaa_pkg::ST_SCAN) begin
				if (chk_idx_q < used_q && match.fit) begin
					found_q <= 1'b1;
				end else if (!scan_end) begin
					chk_idx_q <= next_idx;
				end
			end else if (state_q == rtaa_pkg::ST_UPDATE) begin
				if (opening) begin
					used_q <= used_q + UW'(1);
				end
				swap_slot_q  <= res_nx.swapchain_slot;
				swap_known_q <= res_nx.swapchain_known;
			end
			if (state_q == rtaa_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

	// The fill count never passes the table depth.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(SLOT_COUNT))
		else $error("slot fill count exceeds table depth");

	// The scan index never passes the fill count.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtaa_pkg::ST_SCAN |-> chk_idx_q <= used_q)
		else $error("scan index beyond filled slots");

	// A result never reports both an opened slot and overflow.
	a_open_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[6] && m_tdata[7]))
		else $error("opened slot and overflow reported together");

	// The swapchain record is forgotten only by a request that clears the table.
	a_swap_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(swap_known_q) |-> $past(s_accept && s_tuser[0]))
		else $error("swapchain record lost without a table clear");

	// An opened slot always grows the fill count by one.
	a_open_grow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtaa_pkg::ST_UPDATE && opening |=> used_q == $past(used_q) + UW'(1))
		else $error("opened slot did not advance the fill count");

endmodule
